### rtl/pmd_pkg.sv
`default_nettype none
package pmd_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned BTN_W    = 3;
   localparam int unsigned EVENT_W  = 4;
   localparam int unsigned WHEEL_W  = 4;
   localparam int unsigned POS_W    = 2;

   // position of each byte in a four-byte packet
   localparam logic [POS_W-1:0] POS_FIRST = 2'd0;
   localparam logic [POS_W-1:0] POS_X     = 2'd1;
   localparam logic [POS_W-1:0] POS_Y     = 2'd2;
   localparam logic [POS_W-1:0] POS_LAST  = 2'd3;

   // one complete packet as captured by the collector
   typedef struct packed {
      logic [BYTE_W-1:0] status_byte;
      logic [BYTE_W-1:0] x_byte;
      logic [BYTE_W-1:0] y_byte;
      logic [BYTE_W-1:0] z_byte;
   } packet_type;

endpackage
`default_nettype wire

### rtl/pmd_collect.sv
`default_nettype none
module pmd_collect
   import pmd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [BYTE_W-1:0] req_rx_byte,
   input  wire logic              pkt_take,
   output logic                   req_ready,
   output logic                   pkt_valid,
   output packet_type             pkt,
   output logic [POS_W-1:0]       byte_pos
);

   logic [POS_W-1:0]  pos_ff;
   logic [POS_W-1:0]  pos_in;
   logic              pkt_valid_ff;
   logic              pkt_valid_in;
   packet_type        pkt_ff;
   logic [BYTE_W-1:0] status_ff;
   logic [BYTE_W-1:0] x_ff;
   logic [BYTE_W-1:0] y_ff;
   logic              accept;
   logic              closing;

   // take a beat whenever the packet stage is empty or draining
   assign req_ready = !pkt_valid_ff || pkt_take;
   assign accept    = req_valid && req_ready;
   assign closing   = accept && (pos_ff == POS_LAST);

   assign pos_in       = accept ? pos_ff + 1'b1 : pos_ff;
   assign pkt_valid_in = closing ? 1'b1 : (pkt_take ? 1'b0 : pkt_valid_ff);

   // control: byte position wraps with no resync
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_FIRST;
         pkt_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         pkt_valid_ff <= pkt_valid_in;
      end
   end

   // hold the first three bytes, capture the packet on the fourth
   always_ff @(posedge clock) begin
      if (accept) begin
         case (pos_ff)
            POS_FIRST: status_ff <= req_rx_byte;
            POS_X:     x_ff      <= req_rx_byte;
            POS_Y:     y_ff      <= req_rx_byte;
            default:   pkt_ff    <= '{status_byte: status_ff, x_byte: x_ff,
                                      y_byte: y_ff, z_byte: req_rx_byte};
         endcase
      end
   end

   assign pkt_valid = pkt_valid_ff;
   assign pkt       = pkt_ff;
   assign byte_pos  = pos_ff;

endmodule
`default_nettype wire

### rtl/pmd_decode.sv
`default_nettype none
module pmd_decode
   import pmd_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      pkt_valid,
   input  wire packet_type                pkt,
   input  wire logic                      rsp_ready,
   output logic                           pkt_take,
   output logic                           rsp_valid,
   output logic        [EVENT_W-1:0]      rsp_button_events,
   output logic signed [BYTE_W-1:0]       rsp_move_x,
   output logic signed [BYTE_W-1:0]       rsp_move_y,
   output logic signed [WHEEL_W-1:0]      rsp_wheel_z
);

   logic [BTN_W-1:0]   prev_ff;
   logic [BTN_W-1:0]   btn;
   logic [BTN_W-1:0]   changed;
   logic [BTN_W-1:0]   pressed;
   logic [BTN_W-1:0]   released;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [EVENT_W-1:0] events_ff;
   logic [EVENT_W-1:0] events_in;
   logic [BYTE_W-1:0]  x_ff;
   logic [BYTE_W-1:0]  y_ff;
   logic [BYTE_W-1:0]  y_in;
   logic [WHEEL_W-1:0] z_ff;

   // load the result register when it is empty or being taken
   assign pkt_take = pkt_valid && (!rsp_valid_ff || rsp_ready);

   // button edges against the previous packet; the two masks never overlap
   assign btn       = pkt.status_byte[BTN_W-1:0];
   assign changed   = btn ^ prev_ff;
   assign pressed   = changed & btn;
   assign released  = changed & prev_ff;
   assign events_in = {pressed, 1'b0} | {1'b0, released};

   // negate Y, wrapping so that -128 stays -128
   assign y_in = ~pkt.y_byte + 1'b1;

   assign rsp_valid_in = pkt_take ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pkt_take) begin
            prev_ff <= btn;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pkt_take) begin
         events_ff <= events_in;
         x_ff      <= pkt.x_byte;
         y_ff      <= y_in;
         z_ff      <= pkt.z_byte[WHEEL_W-1:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_button_events = events_ff;
   assign rsp_move_x        = x_ff;
   assign rsp_move_y        = y_ff;
   assign rsp_wheel_z       = z_ff;

endmodule
`default_nettype wire

### rtl/ps2_mouse_packet_decoder.sv
// Wheel-mouse packet decoder. Received bytes come in on req_rx_byte, one per
// beat, and every fourth byte closes a four-byte packet with no check for
// synchronization. Each packet yields one result: button press/release edge
// bits against the previous packet, X motion, negated Y motion and the wheel
// nibble as a signed 4-bit value. The block takes one byte per cycle while
// req_ready is high; a result passes through the packet capture register
// and then the result register after its fourth byte is accepted. Backpressure
// on rsp_ready stalls req_ready only once both of those registers are full.
`default_nettype none
module ps2_mouse_packet_decoder
   import pmd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [BYTE_W-1:0]     req_rx_byte,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic        [EVENT_W-1:0]  rsp_button_events,
   output logic signed [BYTE_W-1:0]   rsp_move_x,
   output logic signed [BYTE_W-1:0]   rsp_move_y,
   output logic signed [WHEEL_W-1:0]  rsp_wheel_z
);

   logic             pkt_valid;
   logic             pkt_take;
   packet_type       pkt;
   logic [POS_W-1:0] byte_pos;

   pmd_collect u_collect (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .pkt_take    (pkt_take),
      .req_ready   (req_ready),
      .pkt_valid   (pkt_valid),
      .pkt         (pkt),
      .byte_pos    (byte_pos)
   );

   pmd_decode u_decode (
      .clock             (clock),
      .reset             (reset),
      .pkt_valid         (pkt_valid),
      .pkt               (pkt),
      .rsp_ready         (rsp_ready),
      .pkt_take          (pkt_take),
      .rsp_valid         (rsp_valid),
      .rsp_button_events (rsp_button_events),
      .rsp_move_x        (rsp_move_x),
      .rsp_move_y        (rsp_move_y),
      .rsp_wheel_z       (rsp_wheel_z)
   );

   // a fourth byte always lands in the packet stage
   a_close_fills: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && byte_pos == POS_LAST |=> pkt_valid)
      else $error("closing byte did not fill packet stage");

   // position advances by exactly one per accepted beat
   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> byte_pos == $past(byte_pos) + 2'd1)
      else $error("byte position did not advance");

   // a new result only comes from a packet in the capture stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(pkt_valid))
      else $error("result without captured packet");

   // a packet is never dropped while the result side is stalled
   a_pkt_hold: assert property (@(posedge clock) disable iff (reset)
      pkt_valid && !pkt_take |=> pkt_valid && $stable(pkt))
      else $error("stalled packet lost");

endmodule
`default_nettype wire
